### rtl/sdhct_pkg.sv
// Shared types, constants and a helper function of the SD host command tracker.
package sdhct_pkg;

    // Item kinds.
    localparam logic ACT_ISSUE = 1'b0;
    localparam logic ACT_IRQ   = 1'b1;

    // Command indexes with special handling.
    localparam logic [5:0] CMD_STOP_TRANS  = 6'd12;
    localparam logic [5:0] CMD_READ_SINGLE = 6'd17;

    // Response kinds.
    localparam logic [3:0] RSP_NONE = 4'd0;
    localparam logic [3:0] RSP_R1   = 4'd1;
    localparam logic [3:0] RSP_R1B  = 4'd2;
    localparam logic [3:0] RSP_R2   = 4'd3;
    localparam logic [3:0] RSP_R3   = 4'd4;
    localparam logic [3:0] RSP_R4   = 4'd5;
    localparam logic [3:0] RSP_R5   = 4'd6;
    localparam logic [3:0] RSP_R5B  = 4'd7;
    localparam logic [3:0] RSP_R6   = 4'd8;

    // Response capture codes.
    localparam logic [1:0] CAP_NONE  = 2'd0;
    localparam logic [1:0] CAP_ALL   = 2'd1;
    localparam logic [1:0] CAP_WORD3 = 2'd2;
    localparam logic [1:0] CAP_WORD0 = 2'd3;

    // Command status codes.
    localparam logic [1:0] DONE_PENDING = 2'd0;
    localparam logic [1:0] DONE_OK      = 2'd1;
    localparam logic [1:0] DONE_FAILED  = 2'd2;
    localparam logic [1:0] DONE_NO_CMD  = 2'd3;

    // Configuration register indexes.
    localparam logic REG_MIXER_IN_CMD = 1'b0;

    // Interrupt status bits.
    localparam int ST_CC  = 0;
    localparam int ST_TC  = 1;
    localparam int ST_BWR = 4;
    localparam int ST_BRR = 5;

    // Interrupt enable mask on issue, buffer ready bits and error mask.
    localparam logic [31:0] IEN_BASE  = 32'h02FF_00C3;
    localparam logic [31:0] IEN_BUF   = 32'h0000_0030;
    localparam logic [31:0] ERR_MASK  = 32'h137F_8080;

    // Transfer type bits.
    localparam logic [31:0] XT_CCCEN = 32'h0008_0000;
    localparam logic [31:0] XT_CICEN = 32'h0010_0000;
    localparam logic [31:0] XT_DPSEL = 32'h0020_0000;

    // Mixer bits.
    localparam logic [5:0] MX_DMAEN  = 6'h01;
    localparam logic [5:0] MX_BCEN   = 6'h02;
    localparam logic [5:0] MX_DTDSEL = 6'h10;
    localparam logic [5:0] MX_MSBSEL = 6'h20;

    // Watermark ceiling in words.
    localparam logic [9:0] WM_MAX = 10'h080;

    typedef struct packed {
        logic        action;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_argument;
        logic [3:0]  response_kind;
        logic        has_data;
        logic [15:0] block_count;
        logic [11:0] block_bytes;
        logic [31:0] dma_address;
        logic [31:0] irq_status;
    } t_item;

    typedef struct packed {
        logic [31:0] transfer_type_word;
        logic [31:0] argument_word;
        logic [5:0]  mixer_word;
        logic [31:0] block_attr_word;
        logic [23:0] watermark_word;
        logic [31:0] irq_enable_word;
        logic [31:0] dma_address_word;
        logic [1:0]  response_capture;
        logic        move_block;
        logic        move_is_read;
        logic [1:0]  done_status;
    } t_result;

    // Tracked command state.
    typedef struct packed {
        logic        command_active;
        logic [5:0]  active_index;
        logic [3:0]  active_response_kind;
        logic        active_has_data;
        logic [15:0] blocks_left;
    } t_track;

    // Result of one item together with the state it leaves.
    typedef struct packed {
        t_result res;
        t_track  trk;
    } t_step;

    // Response type, CRC check and index check bits for a response kind.
    function automatic logic [31:0] response_bits(input logic [3:0] kind);
        logic [31:0] bits;
        case (kind)
            RSP_R2:                   bits = 32'h0001_0000 | XT_CCCEN;
            RSP_R3, RSP_R4:           bits = 32'h0002_0000;
            RSP_R1, RSP_R5, RSP_R6:   bits = 32'h0002_0000 | XT_CICEN | XT_CCCEN;
            RSP_R1B, RSP_R5B:         bits = 32'h0003_0000 | XT_CICEN | XT_CCCEN;
            default:                  bits = 32'h0;
        endcase
        return bits;
    endfunction

endpackage

### rtl/sdhct_if.sv
// Valid/ready channel interfaces for command items and result items.
interface sdhct_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_argument;
    logic [3:0]  response_kind;
    logic        has_data;
    logic [15:0] block_count;
    logic [11:0] block_bytes;
    logic [31:0] dma_address;
    logic [31:0] irq_status;

    modport source (
        output valid, action, cmd_index, cmd_argument, response_kind, has_data,
               block_count, block_bytes, dma_address, irq_status,
        input  ready
    );
    modport sink (
        input  valid, action, cmd_index, cmd_argument, response_kind, has_data,
               block_count, block_bytes, dma_address, irq_status,
        output ready
    );
endinterface

interface sdhct_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] transfer_type_word;
    logic [31:0] argument_word;
    logic [5:0]  mixer_word;
    logic [31:0] block_attr_word;
    logic [23:0] watermark_word;
    logic [31:0] irq_enable_word;
    logic [31:0] dma_address_word;
    logic [1:0]  response_capture;
    logic        move_block;
    logic        move_is_read;
    logic [1:0]  done_status;

    modport source (
        output valid, transfer_type_word, argument_word, mixer_word, block_attr_word,
               watermark_word, irq_enable_word, dma_address_word, response_capture,
               move_block, move_is_read, done_status,
        input  ready
    );
    modport sink (
        input  valid, transfer_type_word, argument_word, mixer_word, block_attr_word,
               watermark_word, irq_enable_word, dma_address_word, response_capture,
               move_block, move_is_read, done_status,
        output ready
    );
endinterface

### rtl/sdhct_cfg.sv
// APB configuration register of the SD host command tracker.
module sdhct_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    output logic        o_mixer_in_cmd
);

    logic r_mixer_in_cmd;
    logic wr_en;

    // A write completes in the access cycle; the port never waits.
    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite && (i_paddr[2] == sdhct_pkg::REG_MIXER_IN_CMD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mixer_in_cmd <= 1'b0;
        end else if (wr_en) begin
            r_mixer_in_cmd <= i_pwdata[0];
        end
    end

    // Read back the register; other addresses read as zero.
    always_comb begin
        o_prdata = 32'h0;
        if ((i_paddr[2] == sdhct_pkg::REG_MIXER_IN_CMD) && (i_paddr[1:0] == 2'b00)) begin
            o_prdata = {31'h0, r_mixer_in_cmd};
        end
    end

    assign o_mixer_in_cmd = r_mixer_in_cmd;

endmodule

### rtl/sdhct_issue.sv
// Builds the controller register words for a newly issued command.
module sdhct_issue (
    input  sdhct_pkg::t_item  i_item,
    input  sdhct_pkg::t_track i_trk,
    input  logic              i_mixer_in_cmd,
    output sdhct_pkg::t_step  o_step
);

    logic       use_dma;
    logic       single_read;
    logic [9:0] lvl_raw;
    logic [7:0] lvl;
    logic [5:0] mix;

    always_comb begin
        use_dma     = i_item.has_data && (i_item.dma_address != 32'h0);
        single_read = (i_item.cmd_index == sdhct_pkg::CMD_READ_SINGLE);

        // Watermark is a quarter of the block size, capped.
        lvl_raw = 10'(i_item.block_bytes >> 2);
        lvl     = (lvl_raw > sdhct_pkg::WM_MAX) ? 8'(sdhct_pkg::WM_MAX) : lvl_raw[7:0];

        // Mixer control bits.
        mix = sdhct_pkg::MX_BCEN;
        if (i_item.block_count > 16'd1) begin
            mix = mix | sdhct_pkg::MX_MSBSEL;
        end
        if (single_read) begin
            mix = mix | sdhct_pkg::MX_DTDSEL;
        end
        if (use_dma) begin
            mix = mix | sdhct_pkg::MX_DMAEN;
        end

        o_step = '0;
        o_step.res.argument_word   = i_item.cmd_argument;
        o_step.res.irq_enable_word = sdhct_pkg::IEN_BASE | (use_dma ? 32'h0 : sdhct_pkg::IEN_BUF);
        o_step.res.transfer_type_word = {2'b00, i_item.cmd_index, 24'h0}
                                        | sdhct_pkg::response_bits(i_item.response_kind);
        o_step.res.done_status = sdhct_pkg::DONE_PENDING;

        // Data phase words.
        if (i_item.has_data) begin
            o_step.res.block_attr_word = {i_item.block_count, 4'h0, i_item.block_bytes};
            o_step.res.watermark_word  = single_read ? {16'h0, lvl} : {lvl, 16'h0};
            o_step.res.mixer_word      = mix;
            o_step.res.dma_address_word = use_dma ? i_item.dma_address : 32'h0;
            o_step.res.transfer_type_word = o_step.res.transfer_type_word
                                            | sdhct_pkg::XT_DPSEL
                                            | (i_mixer_in_cmd ? {26'h0, mix} : 32'h0);
        end

        // The new command replaces any tracked one.
        o_step.trk.command_active       = 1'b1;
        o_step.trk.active_index         = i_item.cmd_index;
        o_step.trk.active_response_kind = i_item.response_kind;
        o_step.trk.active_has_data      = i_item.has_data;
        o_step.trk.blocks_left = i_item.has_data ? i_item.block_count : i_trk.blocks_left;
    end

endmodule

### rtl/sdhct_event.sv
// Decodes an interrupt status item against the tracked command.
module sdhct_event (
    input  sdhct_pkg::t_item  i_item,
    input  sdhct_pkg::t_track i_trk,
    output sdhct_pkg::t_step  o_step
);

    logic failed;
    logic complete;
    logic buf_ready;

    always_comb begin
        o_step     = '0;
        o_step.trk = i_trk;
        failed     = (i_item.irq_status & sdhct_pkg::ERR_MASK) != 32'h0;
        complete   = 1'b0;
        buf_ready  = i_item.irq_status[sdhct_pkg::ST_BRR] || i_item.irq_status[sdhct_pkg::ST_BWR];

        if (!i_trk.command_active) begin
            o_step.res.done_status = sdhct_pkg::DONE_NO_CMD;
        end else begin
            // Command complete: pick the response words to capture.
            if (i_item.irq_status[sdhct_pkg::ST_CC]) begin
                case (i_trk.active_response_kind)
                    sdhct_pkg::RSP_NONE: o_step.res.response_capture = sdhct_pkg::CAP_NONE;
                    sdhct_pkg::RSP_R2:   o_step.res.response_capture = sdhct_pkg::CAP_ALL;
                    sdhct_pkg::RSP_R1B: begin
                        o_step.res.response_capture =
                            (i_trk.active_index == sdhct_pkg::CMD_STOP_TRANS)
                            ? sdhct_pkg::CAP_WORD3 : sdhct_pkg::CAP_WORD0;
                    end
                    default:             o_step.res.response_capture = sdhct_pkg::CAP_WORD0;
                endcase
                if (!i_trk.active_has_data) begin
                    complete = 1'b1;
                end
            end

            // One programmed-IO block moves while blocks remain; read wins.
            if (buf_ready && i_trk.active_has_data && (i_trk.blocks_left != 16'h0)) begin
                o_step.res.move_block   = 1'b1;
                o_step.res.move_is_read = i_item.irq_status[sdhct_pkg::ST_BRR];
                o_step.trk.blocks_left  = i_trk.blocks_left - 16'd1;
            end

            if (i_item.irq_status[sdhct_pkg::ST_TC]) begin
                complete = 1'b1;
            end

            // Errors outrank completion; either one ends the command.
            if (failed) begin
                o_step.res.done_status = sdhct_pkg::DONE_FAILED;
            end else if (complete) begin
                o_step.res.done_status = sdhct_pkg::DONE_OK;
            end else begin
                o_step.res.done_status = sdhct_pkg::DONE_PENDING;
            end
            if (failed || complete) begin
                o_step.trk.command_active = 1'b0;
            end
        end
    end

endmodule

### rtl/sd_host_command_tracker.sv
// Top level of the SD host command tracker.
//
// Usage: i_cmd carries items in with valid/ready; action 0 issues a new
// command and yields every controller register word needed to start it,
// action 1 presents an interrupt status word and yields the capture, block
// move and completion decode for the tracked command. o_res carries exactly
// one result item for each input item, in order.
// An accepted item is held in the input register, decoded against the tracked
// state, and its result is loaded into the output register once that register
// is free, which raises o_res.valid.
// Throughput: one item per cycle unless o_res stalls; the tracked state is
// updated in the same cycle the item is decoded; the next item sees it at once.
// When o_res is stalled the output register holds, the input register keeps
// one more item, and i_cmd.ready drops only when both are full.
// The APB port holds one register (mixer bits in the transfer type word);
// write it only while no item is in flight.
// Reset clears the tracked command, the register and both valid flags.
module sd_host_command_tracker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sdhct_in_if.sink      i_cmd,
    sdhct_out_if.source   o_res,
    input  logic          i_psel,
    input  logic          i_penable,
    input  logic          i_pwrite,
    input  logic [2:0]    i_paddr,
    input  logic [31:0]   i_pwdata,
    output logic [31:0]   o_prdata,
    output logic          o_pready
);

    logic                 mixer_in_cmd;
    logic                 r_in_valid;
    sdhct_pkg::t_item     r_in;
    logic                 r_out_valid;
    sdhct_pkg::t_result   r_out;
    sdhct_pkg::t_track    r_trk;
    sdhct_pkg::t_track    n_trk;
    sdhct_pkg::t_item     in_item;
    sdhct_pkg::t_step     issue_step;
    sdhct_pkg::t_step     event_step;
    sdhct_pkg::t_step     sel_step;
    logic                 advance;
    logic                 in_accept;

    sdhct_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (i_psel),
        .i_penable      (i_penable),
        .i_pwrite       (i_pwrite),
        .i_paddr        (i_paddr),
        .i_pwdata       (i_pwdata),
        .o_prdata       (o_prdata),
        .o_pready       (o_pready),
        .o_mixer_in_cmd (mixer_in_cmd)
    );

    // Gather the channel payload.
    always_comb begin
        in_item.action        = i_cmd.action;
        in_item.cmd_index     = i_cmd.cmd_index;
        in_item.cmd_argument  = i_cmd.cmd_argument;
        in_item.response_kind = i_cmd.response_kind;
        in_item.has_data      = i_cmd.has_data;
        in_item.block_count   = i_cmd.block_count;
        in_item.block_bytes   = i_cmd.block_bytes;
        in_item.dma_address   = i_cmd.dma_address;
        in_item.irq_status    = i_cmd.irq_status;
    end

    // Handshake: decode moves forward when the output register is free.
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || advance;
    assign in_accept   = i_cmd.valid && i_cmd.ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= in_item;
        end
    end

    sdhct_issue u_issue (
        .i_item         (r_in),
        .i_trk          (r_trk),
        .i_mixer_in_cmd (mixer_in_cmd),
        .o_step         (issue_step)
    );

    sdhct_event u_event (
        .i_item (r_in),
        .i_trk  (r_trk),
        .o_step (event_step)
    );

    // Select by item kind and compute the next tracked state.
    always_comb begin
        sel_step = (r_in.action == sdhct_pkg::ACT_ISSUE) ? issue_step : event_step;
        n_trk    = advance ? sel_step.trk : r_trk;
    end

    // Tracked command state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trk <= '0;
        end else begin
            r_trk <= n_trk;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= sel_step.res;
        end
    end

    // Drive the result channel.
    assign o_res.valid              = r_out_valid;
    assign o_res.transfer_type_word = r_out.transfer_type_word;
    assign o_res.argument_word      = r_out.argument_word;
    assign o_res.mixer_word         = r_out.mixer_word;
    assign o_res.block_attr_word    = r_out.block_attr_word;
    assign o_res.watermark_word     = r_out.watermark_word;
    assign o_res.irq_enable_word    = r_out.irq_enable_word;
    assign o_res.dma_address_word   = r_out.dma_address_word;
    assign o_res.response_capture   = r_out.response_capture;
    assign o_res.move_block         = r_out.move_block;
    assign o_res.move_is_read       = r_out.move_is_read;
    assign o_res.done_status        = r_out.done_status;

endmodule
